FILE: design/assert_macros.svh
// Assertion macros for the checker file of the closure engine.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under async active-low reset
`define NEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nec assertion failed");

// Next-cycle implication under async active-low reset
`define NEC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nec assertion failed");

`endif

FILE: design/nec_pkg.sv
// Shared types, constants and helpers of the NFA epsilon-closure engine.
// No dependencies.
package nec_pkg;

	localparam int NODE_COUNT = 64;
	localparam int NODE_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

	// Field widths fixed by the item format
	localparam int SET_W   = 64;
	localparam int INDEX_W = 6;
	localparam int TAINT_W = 8;

	localparam logic [INDEX_W:0] NODE_LIMIT = (INDEX_W+1)'(NODE_COUNT);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef logic [NODE_COUNT-1:0] set_t;
	typedef logic [NODE_W-1:0]     idx_t;

	typedef struct packed {
		logic                opcode;
		logic [INDEX_W-1:0]  node_index;
		logic [SET_W-1:0]    epsilon_row;
		logic                node_accepting;
		logic [TAINT_W-1:0]  node_taint;
		logic [SET_W-1:0]    start_set;
	} req_t;

	typedef struct packed {
		logic [SET_W-1:0] closure_set;
		logic [SET_W-1:0] accept_set;
		logic             multi_taint;
	} rsp_t;

	typedef struct packed {
		set_t               row;
		logic               accepting;
		logic [TAINT_W-1:0] taint;
	} node_entry_t;

	typedef struct packed {
		logic        en;
		idx_t        addr;
		node_entry_t entry;
	} tbl_wr_t;

	typedef struct packed {
		logic en;
		idx_t addr;
	} tbl_rd_t;

	typedef struct packed {
		logic valid;
		set_t closure;
		set_t accepts;
		logic multi;
	} eng_res_t;

	// Encode a one-hot node set into its node number
	function automatic idx_t onehot_index(set_t oh);
		idx_t idx;
		idx = '0;
		for (int k = 0; k < NODE_COUNT; k++) begin
			if (oh[k]) begin
				idx = idx | idx_t'(k);
			end
		end
		return idx;
	endfunction

endpackage

FILE: design/nec_if.sv
// Valid/ready channel interfaces for request and result transfers.
// Depends on nec_pkg.
interface nec_req_if import nec_pkg::*; ();
	logic valid;
	logic ready;
	req_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface nec_rsp_if import nec_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

FILE: design/nec_node_table.sv
// Node table: one synchronous memory of node entries; read data is registered and appears the cycle after the read.
// Per-entry valid flops make unwritten entries read as zero. Depends on nec_pkg.
module nec_node_table import nec_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  tbl_wr_t     wr,
	input  tbl_rd_t     rd,
	output node_entry_t rd_entry
);

	node_entry_t mem [NODE_COUNT];
	node_entry_t rd_entry_s1;
	logic        rd_vld_s1;
	set_t        vld_q;

	// Write port and registered read data
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.entry;
		end
		if (rd.en) begin
			rd_entry_s1 <= mem[rd.addr];
		end
	end

	// Entry valid bits, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				rd_vld_s1 <= vld_q[rd.addr];
			end
		end
	end

	// Drop data of never-written entries
	assign rd_entry = rd_vld_s1 ? rd_entry_s1 : '0;

endmodule

FILE: design/nec_engine.sv
// Closure sequencer: takes items, writes node entries, walks the closure worklist
// one node read per cycle while a node is pending, and gathers accept and taint summaries. Depends on nec_pkg.
module nec_engine import nec_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  req_t        item,
	output logic        ready,
	output tbl_wr_t     tbl_wr,
	output tbl_rd_t     tbl_rd,
	input  node_entry_t tbl_entry,
	output eng_res_t    res,
	input  logic        res_take
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} state_t;

	state_t             state_q;
	logic               rd_s1;
	idx_t               idx_s1;
	set_t               cur_q;
	set_t               done_q;
	set_t               acc_q;
	logic               have_q;
	logic [TAINT_W-1:0] first_q;
	logic               multi_q;

	set_t pend;
	set_t pick_oh;
	idx_t pick_idx;
	logic query_start;

	// Pick the lowest pending node of the worklist
	assign pend     = cur_q & ~done_q;
	assign pick_oh  = pend & (~pend + 1'b1);
	assign pick_idx = onehot_index(pick_oh);

	assign ready       = (state_q == ST_IDLE);
	assign query_start = take && (item.opcode == OP_QUERY);

	// Table write for a node load, dropped beyond the table
	always_comb begin
		tbl_wr.en              = take && (item.opcode == OP_WRITE)
		                         && ({1'b0, item.node_index} < NODE_LIMIT);
		tbl_wr.addr            = item.node_index[NODE_W-1:0];
		tbl_wr.entry.row       = item.epsilon_row[NODE_COUNT-1:0];
		tbl_wr.entry.accepting = item.node_accepting;
		tbl_wr.entry.taint     = item.node_taint;
	end

	assign tbl_rd.en   = (state_q == ST_RUN) && (pend != '0);
	assign tbl_rd.addr = pick_idx;

	always_comb begin
		res.valid   = (state_q == ST_FINISH);
		res.closure = cur_q;
		res.accepts = acc_q;
		res.multi   = multi_q;
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_s1   <= 1'b0;
		end else begin
			rd_s1 <= tbl_rd.en;
			unique case (state_q)
				ST_IDLE: begin
					if (query_start) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if ((pend == '0) && !rd_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Closure set, visited marks, taint summary and accept marks (of tainted nodes only)
	always_ff @(posedge clk) begin
		if (query_start) begin
			cur_q   <= item.start_set[NODE_COUNT-1:0];
			done_q  <= '0;
			acc_q   <= '0;
			have_q  <= 1'b0;
			first_q <= '0;
			multi_q <= 1'b0;
		end else if (state_q == ST_RUN) begin
			idx_s1 <= pick_idx;
			if (tbl_rd.en) begin
				done_q[pick_idx] <= 1'b1;
			end
			// Merge the successors of the node read last cycle
			if (rd_s1) begin
				cur_q <= cur_q | tbl_entry.row;
				if (tbl_entry.taint != '0) begin
					if (!have_q) begin
						have_q  <= 1'b1;
						first_q <= tbl_entry.taint;
					end else if (tbl_entry.taint != first_q) begin
						multi_q <= 1'b1;
					end
					if (tbl_entry.accepting) begin
						acc_q[idx_s1] <= 1'b1;
					end
				end
			end
		end
	end

endmodule

FILE: design/nfa_epsilon_closure.sv
// Channel  | Dir | Payload                                         | Transfer
// req      | in  | opcode, node_index, epsilon_row, node_accepting,| valid & ready
//          |     | node_taint, start_set                           |
// rsp      | out | closure_set, accept_set, multi_taint            | valid & ready
//
// Node writes are taken while the engine is idle. A query result is offered in the output
// register once the closure of its start set has been walked. Reads issue one per cycle on
// the single port while a node is pending, but a node found through an edge is read only
// after its predecessor's row has merged into the closure set. One item is in work at a
// time; a finished result sits in the output register, so node writes go on while it waits,
// and a second finished query stalls the input until that register drains. Reset clears
// the node table's valid bits at once.
// Depends on nec_pkg, nec_if, nec_node_table and nec_engine.
module nfa_epsilon_closure import nec_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	nec_req_if.sink   req,
	nec_rsp_if.source rsp
);

	tbl_wr_t     tbl_wr;
	tbl_rd_t     tbl_rd;
	node_entry_t tbl_entry;
	eng_res_t    res;
	logic        eng_ready;
	logic        res_take;
	logic        out_vld_q;
	rsp_t        out_q;

	nec_node_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (tbl_wr),
		.rd       (tbl_rd),
		.rd_entry (tbl_entry)
	);

	nec_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (req.valid && eng_ready),
		.item      (req.payload),
		.ready     (eng_ready),
		.tbl_wr    (tbl_wr),
		.tbl_rd    (tbl_rd),
		.tbl_entry (tbl_entry),
		.res       (res),
		.res_take  (res_take)
	);

	assign req.ready = eng_ready;
	assign res_take  = !out_vld_q || rsp.ready;

	// Output register: load a finished result, drop it on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res.valid && res_take) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_take) begin
			out_q.closure_set <= SET_W'(res.closure);
			out_q.accept_set  <= SET_W'(res.accepts);
			out_q.multi_taint <= res.multi;
		end
	end

	assign rsp.valid   = out_vld_q;
	assign rsp.payload = out_q;

endmodule

FILE: design/nec_checker.sv
// Port-level checks of the closure engine, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module nec_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        req_opcode,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [63:0] closure_set,
	input logic [63:0] accept_set,
	input logic        multi_taint
);

	// A stalled result stays offered
	`NEC_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)

	// Accepting nodes reported lie inside the closure
	`NEC_ASSERT_IMP(a_accept_in_closure, clk, arst_n, rsp_valid, (accept_set & ~closure_set) == 64'd0)

	// An empty closure carries no taint conflict and no accepting nodes
	`NEC_ASSERT_IMP(a_empty_no_multi, clk, arst_n, rsp_valid && (closure_set == 64'd0), !multi_taint && (accept_set == 64'd0))

	// A query transfer keeps the block busy the next cycle
	`NEC_ASSERT_NXT(a_query_busy, clk, arst_n, req_valid && req_ready && req_opcode, !req_ready)

endmodule

bind nfa_epsilon_closure nec_checker u_nec_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_opcode  (req.payload.opcode),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.closure_set (rsp.payload.closure_set),
	.accept_set  (rsp.payload.accept_set),
	.multi_taint (rsp.payload.multi_taint)
);
